// ===== src/complex_divider_assert.svh =====
// Assertion macros for the complex divider.
`ifndef COMPLEX_DIVIDER_ASSERT_SVH
`define COMPLEX_DIVIDER_ASSERT_SVH
`ifndef SYNTH
`define CD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define CD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/cd_pkg.sv =====
// Shared types and constants of the complex divider.
`default_nettype none
package cd_pkg;
    localparam int CD_DATA_W   = 16;
    localparam int CD_FRAC_DEF = 8;
    localparam int CD_FRAC_MAX = 24;
    localparam int CD_PROD_W   = 2 * CD_DATA_W;
    localparam int CD_REM_W    = 3 * CD_DATA_W + CD_FRAC_MAX + 1;
    localparam int CD_Q_W      = CD_DATA_W + 2;

    typedef struct packed {
        logic signed [CD_DATA_W-1:0] num_re;
        logic signed [CD_DATA_W-1:0] num_im;
        logic signed [CD_DATA_W-1:0] den_re;
        logic signed [CD_DATA_W-1:0] den_im;
    } t_in;

    typedef struct packed {
        logic signed [CD_DATA_W-1:0] quot_re;
        logic signed [CD_DATA_W-1:0] quot_im;
        logic                        saturated;
        logic                        div_by_zero;
    } t_out;

    typedef struct packed {
        logic [CD_REM_W-1:0]  rem_re;
        logic [CD_REM_W-1:0]  rem_im;
        logic [CD_Q_W-1:0]    q_re;
        logic [CD_Q_W-1:0]    q_im;
        logic [CD_PROD_W-1:0] norm;
        logic                 neg_re;
        logic                 neg_im;
        logic                 dz;
    } t_div;
endpackage
`default_nettype wire

// ===== src/cd_front.sv =====
// Front end: products, then norm and sign/magnitude of both product sums.
`default_nettype none
module cd_front #(
    parameter int FRAC_BITS = cd_pkg::CD_FRAC_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  cd_pkg::t_in     i_data,
    output logic            o_valid,
    input  wire             i_ready,
    output cd_pkg::t_div    o_data
);
    import cd_pkg::*;

    logic                        r_va, r_vb;
    logic                        ready_a, ready_b;
    logic signed [CD_PROD_W-1:0] r_ac, r_bd, r_bc, r_ad, r_cc, r_dd;
    logic                        r_dz;
    logic signed [CD_PROD_W:0]   re_sum, im_sum;
    t_div                        n_div, r_div;

    assign ready_b = !r_vb || i_ready;
    assign ready_a = !r_va || ready_b;
    assign o_ready = ready_a;

    always_ff @(posedge i_clk) begin
        if (ready_a) begin
            r_ac <= i_data.num_re * i_data.den_re;
            r_bd <= i_data.num_im * i_data.den_im;
            r_bc <= i_data.num_im * i_data.den_re;
            r_ad <= i_data.num_re * i_data.den_im;
            r_cc <= i_data.den_re * i_data.den_re;
            r_dd <= i_data.den_im * i_data.den_im;
            r_dz <= (i_data.den_re == '0) && (i_data.den_im == '0);
        end
        if (ready_b) begin
            r_div <= n_div;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (ready_a) r_va <= i_valid;
            if (ready_b) r_vb <= r_va;
        end
    end

    always_comb begin
        re_sum = {r_ac[CD_PROD_W-1], r_ac} + {r_bd[CD_PROD_W-1], r_bd};
        im_sum = {r_bc[CD_PROD_W-1], r_bc} - {r_ad[CD_PROD_W-1], r_ad};
        n_div        = '0;
        n_div.norm   = CD_PROD_W'(r_cc) + CD_PROD_W'(r_dd);
        n_div.neg_re = re_sum[CD_PROD_W];
        n_div.neg_im = im_sum[CD_PROD_W];
        // Magnitudes fit in the product width as unsigned values; the largest
        // one has the top bit set, so it is zero extended before the shift.
        n_div.rem_re = CD_REM_W'($unsigned(CD_PROD_W'(re_sum[CD_PROD_W] ? -re_sum : re_sum)))
                       << FRAC_BITS;
        n_div.rem_im = CD_REM_W'($unsigned(CD_PROD_W'(im_sum[CD_PROD_W] ? -im_sum : im_sum)))
                       << FRAC_BITS;
        n_div.dz     = r_dz;
    end

    assign o_valid = r_vb;
    assign o_data  = r_div;
endmodule
`default_nettype wire

// ===== src/cd_cell.sv =====
// One restoring division cell: settles quotient bit K of both parts.
`default_nettype none
module cd_cell #(
    parameter int K = 0
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  cd_pkg::t_div    i_data,
    output logic            o_valid,
    input  wire             i_ready,
    output cd_pkg::t_div    o_data
);
    import cd_pkg::*;

    logic                r_valid;
    t_div                r_data, n_data;
    logic [CD_REM_W-1:0] dsh;
    logic                ge_re, ge_im;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        dsh    = CD_REM_W'(i_data.norm) << K;
        ge_re  = i_data.rem_re >= dsh;
        ge_im  = i_data.rem_im >= dsh;
        n_data = i_data;
        if (ge_re) n_data.rem_re = i_data.rem_re - dsh;
        if (ge_im) n_data.rem_im = i_data.rem_im - dsh;
        n_data.q_re[K] = ge_re;
        n_data.q_im[K] = ge_im;
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

// ===== src/complex_divider.sv =====
// Top level of the pipelined complex divider.
// The block divides one complex number by another in signed fixed point.
// Each input beat on i_data (valid/ready) carries num_re, num_im, den_re and
// den_im; each output beat on o_data carries quot_re, quot_im, saturated and
// div_by_zero. Every input beat gives exactly one output beat, in order.
// The pipeline has two front stages for products and sums, one division
// cell per quotient bit (CD_DATA_W + 2 of them), and one output stage that
// clamps the result.
// Throughput is one beat per cycle while i_ready holds; the cell chain is
// fully pipelined and each cell settles one quotient bit of both parts.
// Every stage has its own valid bit, so when the receiver stalls, empty
// stages still fill and the block keeps taking beats until the chain is full.
// A quotient outside the output range is clamped and flags saturated. A zero
// denominator gives zero parts with div_by_zero set.
// Reset is synchronous and active low; it clears all valid bits, so the
// pipeline comes up empty and o_ready is high right after reset.
`default_nettype none
module complex_divider #(
    parameter int FRAC_BITS = cd_pkg::CD_FRAC_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_ready,
    input  cd_pkg::t_in  i_data,
    output logic         o_valid,
    input  wire          i_ready,
    output cd_pkg::t_out o_data
);
    import cd_pkg::*;
    `include "complex_divider_assert.svh"

    localparam int NCELL = CD_Q_W;
    localparam logic [CD_Q_W-1:0] HALF = CD_Q_W'(1) << (CD_DATA_W - 1);

    t_div chain_data  [0:NCELL];
    logic chain_valid [0:NCELL];
    logic chain_ready [0:NCELL];

    logic r_valid;
    t_out r_out, n_out;
    logic out_ready;

    cd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (chain_valid[0]),
        .i_ready (chain_ready[0]),
        .o_data  (chain_data[0])
    );

    // Cells run from the top quotient bit down to bit zero. The top bit only
    // ever marks a quotient far out of range, which the clamp catches.
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        cd_cell #(.K(NCELL - 1 - g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .o_ready (chain_ready[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .i_ready (chain_ready[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    assign out_ready          = !r_valid || i_ready;
    assign chain_ready[NCELL] = out_ready;

    // Clamp both magnitudes and restore the signs; a zero denominator gives zero parts.
    always_comb begin
        logic [CD_Q_W-1:0] mre, mim;
        logic              sat;
        sat = 1'b0;
        mre = chain_data[NCELL].q_re;
        mim = chain_data[NCELL].q_im;
        if (chain_data[NCELL].neg_re) begin
            if (mre > HALF) begin mre = HALF; sat = 1'b1; end
        end else begin
            if (mre > HALF - 1'b1) begin mre = HALF - 1'b1; sat = 1'b1; end
        end
        if (chain_data[NCELL].neg_im) begin
            if (mim > HALF) begin mim = HALF; sat = 1'b1; end
        end else begin
            if (mim > HALF - 1'b1) begin mim = HALF - 1'b1; sat = 1'b1; end
        end
        n_out.quot_re = CD_DATA_W'(chain_data[NCELL].neg_re ? -mre : mre);
        n_out.quot_im = CD_DATA_W'(chain_data[NCELL].neg_im ? -mim : mim);
        n_out.saturated   = sat;
        n_out.div_by_zero = 1'b0;
        if (chain_data[NCELL].dz) begin
            n_out = '0;
            n_out.div_by_zero = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_ready) begin
            r_valid <= chain_valid[NCELL];
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

    `CD_ASSERT_NOW(a_dz_zero, i_clk, i_rst_n, o_valid && o_data.div_by_zero, (o_data.quot_re == '0) && (o_data.quot_im == '0) && !o_data.saturated, "zero denominator beat has nonzero parts")
    `CD_ASSERT_NOW(a_sat_limit, i_clk, i_rst_n, o_valid && o_data.saturated, (o_data.quot_re == CD_DATA_W'(HALF)) || (o_data.quot_re == CD_DATA_W'(HALF - 1'b1)) || (o_data.quot_im == CD_DATA_W'(HALF)) || (o_data.quot_im == CD_DATA_W'(HALF - 1'b1)), "saturated beat without a limit value")
    `CD_ASSERT_NEXT(a_out_fill, i_clk, i_rst_n, chain_valid[NCELL] && out_ready, o_valid, "finished item lost at the output stage")
endmodule
`default_nettype wire
